// File: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion macros for the resampler RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property checked at every rising clock edge outside reset.
`define ASSERT_PROP(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition that must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define ASSERT_PROP(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, cond, msg)

`endif

`endif

// File: hdl/lirs_pkg.sv
// ----------------------------------------------------------------------------
// Resampler package
// Shared constants, register indexes and types of the linear resampler.
// ----------------------------------------------------------------------------
`default_nettype none

package lirs_pkg;

  localparam int FRAC_BITS     = 16;
  localparam int SAMPLE_W      = 16;
  localparam int OUT_W         = 24;
  localparam int RATE_W        = 18;
  localparam int OUT_LEN_W     = 12;
  localparam int IN_LEN_W      = 14;
  localparam int POS_W         = 30;
  localparam int IDX_W         = POS_W - FRAC_BITS;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 18;
  localparam int MAX_BLOCK_OUT = 2048;
  localparam int DEF_MAX_OUTS  = 8;

  localparam logic [RATE_W-1:0]    RATE_RESET    = RATE_W'(65536);
  localparam logic [OUT_LEN_W-1:0] OUT_LEN_RESET = OUT_LEN_W'(1024);
  localparam logic [IN_LEN_W-1:0]  IN_LEN_RESET  = IN_LEN_W'(1025);

  localparam logic [CFG_IDX_W-1:0] REG_RATE_STEP     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_BLOCK_LEN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IN_BLOCK_LEN  = 2'd2;

  typedef struct packed {
    logic [RATE_W-1:0]    rate_step;
    logic [OUT_LEN_W-1:0] n_out;
    logic [IN_LEN_W-1:0]  last_in;
  } cfg_t;

endpackage

`default_nettype wire

// File: hdl/lirs_cfg_regs.sv
// ----------------------------------------------------------------------------
// Resampler configuration registers
// Holds rate step and block lengths and derives the effective block limits.
// ----------------------------------------------------------------------------
`default_nettype none

module lirs_cfg_regs (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [lirs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [lirs_pkg::CFG_DATA_W-1:0] cfg_data,
  output lirs_pkg::cfg_t                     cfg
);
  import lirs_pkg::*;

  logic [RATE_W-1:0]    rate_step;
  logic [OUT_LEN_W-1:0] out_block_len;
  logic [IN_LEN_W-1:0]  in_block_len;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rate_step     <= RATE_RESET;
      out_block_len <= OUT_LEN_RESET;
      in_block_len  <= IN_LEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_RATE_STEP:     rate_step     <= cfg_data[RATE_W-1:0];
        REG_OUT_BLOCK_LEN: out_block_len <= cfg_data[OUT_LEN_W-1:0];
        REG_IN_BLOCK_LEN:  in_block_len  <= cfg_data[IN_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.rate_step = rate_step;
    if ({1'b0, out_block_len} > (OUT_LEN_W + 1)'(MAX_BLOCK_OUT)) begin
      cfg.n_out = OUT_LEN_W'(MAX_BLOCK_OUT);
    end else begin
      cfg.n_out = out_block_len;
    end
    if (in_block_len == '0) begin
      cfg.last_in = '0;
    end else begin
      cfg.last_in = in_block_len - IN_LEN_W'(1);
    end
  end

endmodule

`default_nettype wire

// File: hdl/lirs_interp_unit.sv
// ----------------------------------------------------------------------------
// Resampler interpolation unit
// Shared multiply stage and rounding add, one channel per enabled cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lirs_interp_unit (
  input  wire logic                                clk,
  input  wire logic                                en,
  input  wire logic signed [lirs_pkg::SAMPLE_W-1:0]  s0,
  input  wire logic signed [lirs_pkg::SAMPLE_W-1:0]  s1,
  input  wire logic [lirs_pkg::FRAC_BITS-1:0]        frac,
  output logic signed [lirs_pkg::OUT_W-1:0]          res
);
  import lirs_pkg::*;

  localparam int DIFF_W = SAMPLE_W + 1;
  localparam int PROD_W = DIFF_W + FRAC_BITS + 1;
  localparam int SUM_W  = PROD_W + 1;
  localparam int SH     = FRAC_BITS - 8;
  localparam logic [SUM_W-1:0] RND = SUM_W'(1) << (SH - 1);

  logic signed [DIFF_W-1:0]   diff;
  logic signed [PROD_W-1:0]   prod;
  logic signed [SAMPLE_W-1:0] s0_q;
  logic signed [SUM_W-1:0]    sum;
  logic signed [SUM_W-1:0]    shifted;

  assign diff = DIFF_W'(s1) - DIFF_W'(s0);

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= diff * $signed({1'b0, frac});
      s0_q <= s0;
    end
  end

  always_comb begin
    sum = $signed({{(SUM_W - SAMPLE_W - FRAC_BITS){s0_q[SAMPLE_W-1]}}, s0_q, {FRAC_BITS{1'b0}}})
        + $signed({prod[PROD_W-1], prod})
        + $signed(RND);
    shifted = sum >>> SH;
    res = shifted[OUT_W-1:0];
  end

endmodule

`default_nettype wire

// File: hdl/linear_interp_audio_resampler.sv
// ----------------------------------------------------------------------------
// Linear interpolation audio resampler
// Block-wise stereo sample-rate converter with one shared multiplier.
// ----------------------------------------------------------------------------
// Input pairs enter on the s_ channel, left sample in the low half of tdata.
// Each input transaction can cause zero to MAX_OUTS_PER_INPUT output pairs on
// the m_ channel; tlast marks the last one caused by that input and tuser
// marks the last output pair of a block. Rate step and block lengths are set
// over the cfg channel; the user must write them only while the block is idle,
// as the block itself does not enforce it. An input transaction passes the
// evaluate state and, per output pair it causes, the left multiply, right
// multiply and finish states; the shared multiplier handles left then right
// of each pair, and a sequencer steps through the outputs one at a time.
// s_tready is high only while no input is in progress.
// A stalled receiver holds the output register and one staged result; the
// sequencer waits until the output register frees up.
// Reset restores the default registers and clears the sample history and
// block position, and drops any pending output.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module linear_interp_audio_resampler #(
  parameter int MAX_OUTS_PER_INPUT = lirs_pkg::DEF_MAX_OUTS
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [lirs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [lirs_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  input  wire logic [31:0]                     s_tdata,   // left_in, right_in
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  output logic [47:0]                          m_tdata,   // left_out, right_out
  output logic                                 m_tuser,   // block_end
  output logic                                 m_tlast    // run_last
);
  import lirs_pkg::*;

  localparam int RUN_W = $clog2(MAX_OUTS_PER_INPUT + 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_EVAL  = 3'd1;
  localparam logic [2:0] ST_MUL_L = 3'd2;
  localparam logic [2:0] ST_MUL_R = 3'd3;
  localparam logic [2:0] ST_FIN   = 3'd4;

  cfg_t cfg;

  logic [2:0]           state;
  logic [SAMPLE_W-1:0]  prev_left, prev_right, cur_left, cur_right;
  logic [IN_LEN_W-1:0]  in_index, cur_index;
  logic                 is_last;
  logic [OUT_LEN_W-1:0] out_index;
  logic [POS_W-1:0]     position_acc;
  logic [RUN_W-1:0]     run_count;
  logic                 use_interp;
  logic [FRAC_BITS-1:0] frac;
  logic                 pend_block_end;
  logic                 hold_valid;
  logic [OUT_W-1:0]     hold_left, hold_right;
  logic                 hold_block_end;

  logic [IN_LEN_W:0]    idx_next;
  logic                 loop_ok, hit_interp, hit_clamp, emit, out_free;
  logic                 out_load;
  logic                 unit_en;
  logic signed [SAMPLE_W-1:0] unit_s0, unit_s1;
  logic signed [OUT_W-1:0]    unit_res;

  lirs_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  lirs_interp_unit u_interp (
    .clk  (clk),
    .en   (unit_en),
    .s0   (unit_s0),
    .s1   (unit_s1),
    .frac (frac),
    .res  (unit_res)
  );

  assign s_tready = (state == ST_IDLE);
  assign out_free = !m_tvalid || m_tready;
  assign out_load = (state == ST_EVAL) && hold_valid && out_free;

  always_comb begin
    idx_next   = (IN_LEN_W + 1)'(position_acc[POS_W-1:FRAC_BITS]) + (IN_LEN_W + 1)'(1);
    loop_ok    = (out_index < cfg.n_out) && (run_count < RUN_W'(MAX_OUTS_PER_INPUT));
    hit_interp = (idx_next == {1'b0, cur_index});
    hit_clamp  = (idx_next < {1'b0, cur_index}) || is_last;
    emit       = loop_ok && (hit_interp || hit_clamp);
    unit_en    = (state == ST_MUL_L) || (state == ST_MUL_R);
    unit_s1    = (state == ST_MUL_L) ? cur_left : cur_right;
    if (state == ST_MUL_L) begin
      unit_s0 = use_interp ? prev_left : cur_left;
    end else begin
      unit_s0 = use_interp ? prev_right : cur_right;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      prev_left    <= '0;
      prev_right   <= '0;
      in_index     <= '0;
      out_index    <= '0;
      position_acc <= '0;
      run_count    <= '0;
      hold_valid   <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            cur_left  <= s_tdata[15:0];
            cur_right <= s_tdata[31:16];
            cur_index <= (in_index > cfg.last_in) ? cfg.last_in : in_index;
            is_last   <= (in_index >= cfg.last_in);
            run_count <= '0;
            state     <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          if (!hold_valid || out_free) begin
            if (hold_valid) begin
              m_tdata    <= {hold_right, hold_left};
              m_tuser    <= hold_block_end;
              m_tlast    <= !emit;
              hold_valid <= 1'b0;
            end
            if (emit) begin
              use_interp     <= hit_interp;
              frac           <= hit_interp ? position_acc[FRAC_BITS-1:0] : '0;
              pend_block_end <= ((out_index + OUT_LEN_W'(1)) == cfg.n_out);
              state          <= ST_MUL_L;
            end else begin
              prev_left  <= cur_left;
              prev_right <= cur_right;
              if (is_last) begin
                in_index     <= '0;
                out_index    <= '0;
                position_acc <= '0;
              end else begin
                in_index <= cur_index + IN_LEN_W'(1);
              end
              state <= ST_IDLE;
            end
          end
        end
        ST_MUL_L: begin
          state <= ST_MUL_R;
        end
        ST_MUL_R: begin
          hold_left <= unit_res;
          state     <= ST_FIN;
        end
        ST_FIN: begin
          hold_right     <= unit_res;
          hold_block_end <= pend_block_end;
          hold_valid     <= 1'b1;
          out_index      <= out_index + OUT_LEN_W'(1);
          position_acc   <= position_acc + POS_W'(cfg.rate_step);
          run_count      <= run_count + RUN_W'(1);
          state          <= ST_EVAL;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `ASSERT_PROP(a_block_end_is_run_last, clk, rst, (m_tvalid && m_tuser) |-> m_tlast, "block end without run end")
  `ASSERT_PROP(a_idle_no_staged, clk, rst, s_tready |-> !hold_valid, "staged result left while idle")
  `ASSERT_PROP(a_stall_keeps_staged, clk, rst, (state == ST_EVAL && hold_valid && !out_free) |=> hold_valid, "staged result lost during stall")
  `ASSERT_NEVER(a_run_bound, clk, rst, run_count > RUN_W'(MAX_OUTS_PER_INPUT), "too many results for one input")

endmodule

`default_nettype wire
